[rtl/rkcu_pkg.sv]
`default_nettype none

package rkcu_pkg;

    localparam int WORD_W        = 24;
    localparam int STEP_W        = 23;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t WORD_MAX = 24'sh7FFFFF;
    localparam word_t WORD_MIN = 24'sh800000;

    localparam logic signed [2*WORD_W-1:0] WIDE_MAX = 48'sh0000007FFFFF;
    localparam logic signed [2*WORD_W-1:0] WIDE_MIN = 48'shFFFFFF800000;

    typedef enum logic [1:0] {
        MODEL_GL = 2'd0,
        MODEL_GS = 2'd1,
        MODEL_WS = 2'd2
    } model_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL = 3'd0,
        CFG_STEP  = 3'd1,
        CFG_P1    = 3'd2,
        CFG_P2    = 3'd3,
        CFG_P3    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        model;
        logic [STEP_W-1:0] time_step;
        word_t             p1;
        word_t             p2;
        word_t             p3;
    } cfg_t;

    // one cell in flight: inputs, four working slots and the clamp flag
    typedef struct packed {
        logic [1:0] model;
        word_t      x1;
        word_t      x2;
        word_t      w0;
        word_t      w1;
        word_t      w2;
        word_t      w3;
        logic       flag;
    } cell_t;

    typedef struct packed {
        word_t val;
        logic  sat;
    } sat_t;

    // fixed-point one, limited to the largest word for wide fractions
    function automatic word_t one_value(input int f);
        return (f >= 23) ? WORD_MAX : word_t'(longint'(1) << f);
    endfunction

    function automatic sat_t clamp_wide(input logic signed [2*WORD_W-1:0] v);
        sat_t r;
        if (v > WIDE_MAX)
        begin
            r.val = WORD_MAX;
            r.sat = 1'b1;
        end
        else if (v < WIDE_MIN)
        begin
            r.val = WORD_MIN;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = v[WORD_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t clamp_sum(input logic signed [WORD_W:0] s);
        sat_t r;
        if (s[WORD_W] != s[WORD_W-1])
        begin
            r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = s[WORD_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_t add_sat(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return clamp_sum(s);
    endfunction

    function automatic sat_t sub_sat(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        return clamp_sum(s);
    endfunction

    // product floored by the fraction shift, then clamped
    function automatic sat_t mul_sat(input word_t a, input word_t b, input int unsigned sh);
        logic signed [2*WORD_W-1:0] p;
        p = a * b;
        p = p >>> sh;
        return clamp_wide(p);
    endfunction

endpackage

`default_nettype wire

[rtl/rkcu_chan_if.sv]
`default_nettype none

interface rkcu_in_if;
    logic                  valid;
    logic                  ready;
    rkcu_pkg::word_t       field_first;
    rkcu_pkg::word_t       field_second;

    modport source (output valid, output field_first, output field_second, input ready);
    modport sink   (input valid, input field_first, input field_second, output ready);
endinterface

interface rkcu_out_if;
    logic                  valid;
    logic                  ready;
    rkcu_pkg::word_t       next_first;
    rkcu_pkg::word_t       next_second;
    logic                  saturated;

    modport source (output valid, output next_first, output next_second, output saturated,
                    input ready);
    modport sink   (input valid, input next_first, input next_second, input saturated,
                    output ready);
endinterface

`default_nettype wire

[rtl/rkcu_front.sv]
`default_nettype none

module rkcu_front #(
    parameter int FRAC_BITS = rkcu_pkg::FRAC_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  rkcu_pkg::cfg_t         cfg,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  rkcu_pkg::word_t        in_x1,
    input  rkcu_pkg::word_t        in_x2,
    output logic                   out_valid,
    input  wire                    out_ready,
    output rkcu_pkg::cell_t        out_cell
);
    import rkcu_pkg::*;

    localparam word_t ONE = one_value(FRAC_BITS);

    logic  v1_reg, v2_reg, v3_reg;
    logic  ld1, ld2, ld3;
    cell_t c1_reg, c2_reg, c3_reg;
    cell_t c1_next, c2_next, c3_next;

    sat_t m_uu, m_vv, m_pv, m_pu, a_d, m_ta;
    sat_t a_r2, a_t1, a_t2, m_s, a_oma, a_fk, m_dd, a_pd;
    sat_t m_g1, m_g2, m_f1, m_f2, m_dv;

    assign ld3      = !v3_reg || out_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;
    assign out_valid = v3_reg;
    assign out_cell  = c3_reg;

    // stage 1: first products, difference for Wacker-Scholl
    always_comb
    begin
        m_uu = mul_sat(in_x1, in_x1, FRAC_BITS);
        m_vv = mul_sat(in_x2, in_x2, FRAC_BITS);
        m_pv = mul_sat(cfg.p1, in_x2, FRAC_BITS);
        m_pu = mul_sat(cfg.p1, in_x1, FRAC_BITS);
        a_d  = sub_sat(in_x2, in_x1);
        m_ta = mul_sat(cfg.p2, in_x1, FRAC_BITS);
        c1_next       = '0;
        c1_next.model = cfg.model;
        c1_next.x1    = in_x1;
        c1_next.x2    = in_x2;
        unique case (cfg.model)
            MODEL_GL:
            begin
                c1_next.w0   = m_uu.val;
                c1_next.w1   = m_vv.val;
                c1_next.w2   = m_pv.val;
                c1_next.w3   = m_pu.val;
                c1_next.flag = m_uu.sat | m_vv.sat | m_pv.sat | m_pu.sat;
            end
            MODEL_GS:
            begin
                c1_next.w0   = m_vv.val;
                c1_next.flag = m_vv.sat;
            end
            MODEL_WS:
            begin
                c1_next.w0   = a_d.val;
                c1_next.w2   = m_ta.val;
                c1_next.flag = a_d.sat | m_ta.sat;
            end
            default: ;
        endcase
    end

    // stage 2
    always_comb
    begin
        a_r2  = add_sat(c1_reg.w0, c1_reg.w1);
        a_t1  = sub_sat(c1_reg.x1, c1_reg.w2);
        a_t2  = add_sat(c1_reg.x2, c1_reg.w3);
        m_s   = mul_sat(c1_reg.x1, c1_reg.w0, FRAC_BITS);
        a_oma = sub_sat(ONE, c1_reg.x1);
        a_fk  = add_sat(cfg.p1, cfg.p2);
        m_dd  = mul_sat(c1_reg.w0, c1_reg.w0, FRAC_BITS);
        a_pd  = sub_sat(cfg.p3, c1_reg.w0);
        c2_next = c1_reg;
        unique case (c1_reg.model)
            MODEL_GL:
            begin
                c2_next.w0   = a_r2.val;
                c2_next.w1   = a_t1.val;
                c2_next.w2   = a_t2.val;
                c2_next.flag = c1_reg.flag | a_r2.sat | a_t1.sat | a_t2.sat;
            end
            MODEL_GS:
            begin
                c2_next.w0   = m_s.val;
                c2_next.w1   = a_oma.val;
                c2_next.w2   = a_fk.val;
                c2_next.flag = c1_reg.flag | m_s.sat | a_oma.sat | a_fk.sat;
            end
            MODEL_WS:
            begin
                c2_next.w1   = m_dd.val;
                c2_next.w3   = a_pd.val;
                c2_next.flag = c1_reg.flag | m_dd.sat | a_pd.sat;
            end
            default: ;
        endcase
    end

    // stage 3
    always_comb
    begin
        m_g1 = mul_sat(c2_reg.w1, c2_reg.w0, FRAC_BITS);
        m_g2 = mul_sat(c2_reg.w2, c2_reg.w0, FRAC_BITS);
        m_f1 = mul_sat(cfg.p1, c2_reg.w1, FRAC_BITS);
        m_f2 = mul_sat(c2_reg.w2, c2_reg.x2, FRAC_BITS);
        m_dv = mul_sat(cfg.p1, c2_reg.w3, FRAC_BITS);
        c3_next = c2_reg;
        unique case (c2_reg.model)
            MODEL_GL:
            begin
                c3_next.w1   = m_g1.val;
                c3_next.w2   = m_g2.val;
                c3_next.flag = c2_reg.flag | m_g1.sat | m_g2.sat;
            end
            MODEL_GS:
            begin
                c3_next.w1   = m_f1.val;
                c3_next.w2   = m_f2.val;
                c3_next.flag = c2_reg.flag | m_f1.sat | m_f2.sat;
            end
            MODEL_WS:
            begin
                c3_next.w3   = m_dv.val;
                c3_next.flag = c2_reg.flag | m_dv.sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
                v1_reg <= in_valid;
            if (ld2)
                v2_reg <= v1_reg;
            if (ld3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
            c1_reg <= c1_next;
        if (ld2 && v1_reg)
            c2_reg <= c2_next;
        if (ld3 && v2_reg)
            c3_reg <= c3_next;
    end

endmodule

`default_nettype wire

[rtl/rkcu_div.sv]
`default_nettype none

module rkcu_div #(
    parameter int FRAC_BITS = rkcu_pkg::FRAC_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  rkcu_pkg::cell_t        in_cell,
    output logic                   out_valid,
    input  wire                    out_ready,
    output rkcu_pkg::cell_t        out_cell
);
    import rkcu_pkg::*;

    localparam word_t ONE   = one_value(FRAC_BITS);
    localparam int    NUM_W = WORD_W + FRAC_BITS;
    localparam int    STEPS = 4;
    localparam int    NSTG  = WORD_W / STEPS;

    typedef struct packed {
        logic [WORD_W-1:0] den;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] numlo;
        logic [WORD_W-1:0] quo;
        logic              neg;
        logic              ovf;
    } div_t;

    // restoring division, STEPS quotient bits
    function automatic div_t div_steps(input div_t s_in);
        div_t              s;
        logic [WORD_W:0]   r;
        s = s_in;
        for (int i = 0; i < STEPS; i++)
        begin
            r       = {s.rem, s.numlo[WORD_W-1]};
            s.numlo = {s.numlo[WORD_W-2:0], 1'b0};
            if (r >= {1'b0, s.den})
            begin
                s.rem = WORD_W'(r - {1'b0, s.den});
                s.quo = {s.quo[WORD_W-2:0], 1'b1};
            end
            else
            begin
                s.rem = r[WORD_W-1:0];
                s.quo = {s.quo[WORD_W-2:0], 1'b0};
            end
        end
        return s;
    endfunction

    logic              v_reg  [NSTG];
    cell_t             c_reg  [NSTG];
    div_t              q_reg  [NSTG];
    logic              ld     [NSTG];
    div_t              q_next [NSTG];

    logic signed [WORD_W:0] d_ext;
    logic [WORD_W-1:0]      mag;
    logic [NUM_W-1:0]       num;
    logic [WORD_W-1:0]      hi;
    div_t                   entry;

    always_comb
    begin
        d_ext       = {in_cell.w0[WORD_W-1], in_cell.w0};
        entry.neg   = in_cell.w0[WORD_W-1];
        mag         = WORD_W'(entry.neg ? -d_ext : d_ext);
        num         = {mag, {FRAC_BITS{1'b0}}};
        hi          = WORD_W'(num[NUM_W-1:WORD_W]);
        entry.den   = WORD_W'(in_cell.w1) + WORD_W'(ONE);
        entry.ovf   = hi >= entry.den;
        entry.rem   = entry.ovf ? '0 : hi;
        entry.numlo = num[WORD_W-1:0];
        entry.quo   = '0;
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NSTG-1];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stg
        if (k == NSTG - 1)
        begin : g_last
            assign ld[k] = !v_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign ld[k] = !v_reg[k] || ld[k+1];
        end

        if (k == 0)
        begin : g_first
            assign q_next[k] = div_steps(entry);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (ld[k])
                    v_reg[k] <= in_valid;
            end
            always_ff @(posedge clk)
            begin
                if (ld[k] && in_valid)
                begin
                    c_reg[k] <= in_cell;
                    q_reg[k] <= q_next[k];
                end
            end
        end
        else
        begin : g_rest
            assign q_next[k] = div_steps(q_reg[k-1]);
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (ld[k])
                    v_reg[k] <= v_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (ld[k] && v_reg[k-1])
                begin
                    c_reg[k] <= c_reg[k-1];
                    q_reg[k] <= q_next[k];
                end
            end
        end
    end

    // sign and clamp of the quotient; only Wacker-Scholl items take it
    logic [WORD_W-1:0] quo;
    logic              q_sat;
    word_t             q_val;

    always_comb
    begin
        quo = q_reg[NSTG-1].quo;
        if (!q_reg[NSTG-1].neg)
        begin
            q_sat = q_reg[NSTG-1].ovf || (quo > WORD_W'(WORD_MAX));
            q_val = q_sat ? WORD_MAX : word_t'(quo);
        end
        else
        begin
            q_sat = q_reg[NSTG-1].ovf || (quo > WORD_W'(WORD_MIN));
            q_val = q_sat ? WORD_MIN : word_t'(-quo);
        end
        out_cell = c_reg[NSTG-1];
        if (c_reg[NSTG-1].model == MODEL_WS)
        begin
            out_cell.w0   = q_val;
            out_cell.flag = c_reg[NSTG-1].flag | q_sat;
        end
    end

endmodule

`default_nettype wire

[rtl/rkcu_back.sv]
`default_nettype none

module rkcu_back #(
    parameter int FRAC_BITS = rkcu_pkg::FRAC_BITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  rkcu_pkg::cfg_t         cfg,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  rkcu_pkg::cell_t        in_cell,
    output logic                   out_valid,
    input  wire                    out_ready,
    output rkcu_pkg::word_t        out_first,
    output rkcu_pkg::word_t        out_second,
    output logic                   out_sat
);
    import rkcu_pkg::*;

    logic  va_reg, vb_reg, vc_reg;
    logic  lda, ldb, ldc;
    cell_t ca_reg, cb_reg;
    cell_t ca_next, cb_next;
    word_t n1_reg, n2_reg;
    logic  sat_reg;

    sat_t  s_du, s_dv, m_1, m_2, a_1, a_2;
    word_t dt;

    assign ldc       = !vc_reg || out_ready;
    assign ldb       = !vb_reg || ldc;
    assign lda       = !va_reg || ldb;
    assign in_ready  = lda;
    assign out_valid = vc_reg;
    assign out_first = n1_reg;
    assign out_second = n2_reg;
    assign out_sat   = sat_reg;
    assign dt        = word_t'({1'b0, cfg.time_step});

    // reaction rates du, dv into w0, w1
    always_comb
    begin
        ca_next = in_cell;
        ca_next.w0 = '0;
        ca_next.w1 = '0;
        s_du = '0;
        s_dv = '0;
        unique case (in_cell.model)
            MODEL_GL:
            begin
                s_du = sub_sat(in_cell.x1, in_cell.w1);
                s_dv = sub_sat(in_cell.x2, in_cell.w2);
            end
            MODEL_GS:
            begin
                s_du = sub_sat(in_cell.w1, in_cell.w0);
                s_dv = sub_sat(in_cell.w0, in_cell.w2);
            end
            MODEL_WS:
            begin
                s_du = sub_sat(in_cell.w0, in_cell.w2);
                s_dv = '{val: in_cell.w3, sat: 1'b0};
            end
            default: ;
        endcase
        ca_next.w0   = s_du.val;
        ca_next.w1   = s_dv.val;
        ca_next.flag = in_cell.flag | s_du.sat | s_dv.sat;
    end

    always_comb
    begin
        m_1 = mul_sat(dt, ca_reg.w0, FRAC_BITS);
        m_2 = mul_sat(dt, ca_reg.w1, FRAC_BITS);
        cb_next      = ca_reg;
        cb_next.w0   = m_1.val;
        cb_next.w1   = m_2.val;
        cb_next.flag = ca_reg.flag | m_1.sat | m_2.sat;
    end

    assign a_1 = add_sat(cb_reg.x1, cb_reg.w0);
    assign a_2 = add_sat(cb_reg.x2, cb_reg.w1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (lda)
                va_reg <= in_valid;
            if (ldb)
                vb_reg <= va_reg;
            if (ldc)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lda && in_valid)
            ca_reg <= ca_next;
        if (ldb && va_reg)
            cb_reg <= cb_next;
        if (ldc && vb_reg)
        begin
            n1_reg  <= a_1.val;
            n2_reg  <= a_2.val;
            sat_reg <= cb_reg.flag | a_1.sat | a_2.sat;
        end
    end

endmodule

`default_nettype wire

[rtl/reaction_kinetics_cell_update.sv]
`default_nettype none

// channel   dir  payload                                   handshake
// cell_in   in   field_first, field_second (Q7.16)         valid/ready
// cell_out  out  next_first, next_second, saturated        valid/ready
// cfg       in   cfg_index, cfg_data                       cfg_we, no wait
//
// One cell per cycle unless the output stalls; 3 arithmetic stages, 6 divider
// stages (4 quotient bits each), 3 update stages incl. the output register.
// All models run through the same 12 stages, so order is kept.
// Reset clears valid bits and loads the register defaults.
// A stall at the output holds that item; upstream stages keep filling bubbles.

module reaction_kinetics_cell_update #(
    parameter int FRAC_BITS = rkcu_pkg::FRAC_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    rkcu_in_if.sink                              cell_in,
    rkcu_out_if.source                           cell_out,
    input  wire                                  cfg_we,
    input  wire [rkcu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [rkcu_pkg::WORD_W-1:0]           cfg_data
);
    import rkcu_pkg::*;

    cfg_t  cfg_reg;
    logic  f_valid, f_ready, d_valid, d_ready;
    cell_t f_cell, d_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.model     <= MODEL_GL;
            cfg_reg.time_step <= STEP_W'(6554);
            cfg_reg.p1        <= 24'sd65536;
            cfg_reg.p2        <= '0;
            cfg_reg.p3        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODEL: cfg_reg.model     <= cfg_data[1:0];
                CFG_STEP:  cfg_reg.time_step <= cfg_data[STEP_W-1:0];
                CFG_P1:    cfg_reg.p1        <= cfg_data;
                CFG_P2:    cfg_reg.p2        <= cfg_data;
                CFG_P3:    cfg_reg.p3        <= cfg_data;
                default: ;
            endcase
        end
    end

    rkcu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (cell_in.valid),
        .in_ready  (cell_in.ready),
        .in_x1     (cell_in.field_first),
        .in_x2     (cell_in.field_second),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_cell  (f_cell)
    );

    rkcu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cell   (f_cell),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_cell  (d_cell)
    );

    rkcu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .in_cell    (d_cell),
        .out_valid  (cell_out.valid),
        .out_ready  (cell_out.ready),
        .out_first  (cell_out.next_first),
        .out_second (cell_out.next_second),
        .out_sat    (cell_out.saturated)
    );

    // an empty output slot means every stage can move
    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_out.valid |-> cell_in.ready)
        else $error("input stalled with free output");

    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_in.ready |-> (cell_out.valid && !cell_out.ready))
        else $error("input stalled without output backpressure");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (!cell_out.valid && !d_valid && !f_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
    import rkcu_pkg::*;

    localparam int FRAC = 16;
    localparam int LAT  = 12;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic signed [23:0] nf;
        logic signed [23:0] ns;
        logic               sat;
    } cell_result_t;

    class cell_scoreboard;
        cell_result_t pending[$];
        int mismatches;
        int checked;

        function void note_cell(cell_result_t r);
            pending.push_back(r);
        endfunction

        function void check_cell(logic signed [23:0] nf, logic signed [23:0] ns, logic sat);
            cell_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %0d %0d %0b", nf, ns, sat);
                return;
            end
            e = pending.pop_front();
            if (e.nf !== nf || e.ns !== ns || e.sat !== sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                             e.nf, e.ns, e.sat, nf, ns, sat);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    rkcu_in_if  cell_in ();
    rkcu_out_if cell_out ();

    reaction_kinetics_cell_update #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .cell_in(cell_in), .cell_out(cell_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow of the block's registers
    logic [1:0]         sh_model;
    logic [22:0]        sh_dt;
    logic signed [23:0] sh_p1, sh_p2, sh_p3;

    cell_scoreboard sb;
    int  cycles;
    bit  quiet;       // no idling in the final stretch
    bit  hold_long;   // long receiver hold-off
    int  accepted;
    int  sat_seen;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    function automatic longint clampw(longint v, ref bit f);
        if (v > 64'sd8388607)
        begin
            f = 1;
            return 8388607;
        end
        if (v < -64'sd8388608)
        begin
            f = 1;
            return -8388608;
        end
        return v;
    endfunction

    // >>> on a signed value floors, as the block does
    function automatic longint fx_mul(longint a, longint b, ref bit f);
        return clampw((a * b) >>> FRAC, f);
    endfunction

    function automatic cell_result_t react_step(logic signed [23:0] a, logic signed [23:0] b);
        cell_result_t r;
        bit f;
        longint x1, x2, p1, p2, p3, dt, one, du, dv;
        longint r2, t1, t2, bb, s, oma, fk, d, den, q;
        f = 0;
        x1 = a;
        x2 = b;
        p1 = sh_p1;
        p2 = sh_p2;
        p3 = sh_p3;
        dt = sh_dt;
        one = (FRAC >= 23) ? 8388607 : (longint'(1) << FRAC);
        du = 0;
        dv = 0;
        case (sh_model)
            MODEL_GL:
            begin
                r2 = clampw(fx_mul(x1, x1, f) + fx_mul(x2, x2, f), f);
                t1 = clampw(x1 - fx_mul(p1, x2, f), f);
                t2 = clampw(x2 + fx_mul(p1, x1, f), f);
                du = clampw(x1 - fx_mul(t1, r2, f), f);
                dv = clampw(x2 - fx_mul(t2, r2, f), f);
            end
            MODEL_GS:
            begin
                bb = fx_mul(x2, x2, f);
                s = fx_mul(x1, bb, f);
                oma = clampw(one - x1, f);
                fk = clampw(p1 + p2, f);
                du = clampw(fx_mul(p1, oma, f) - s, f);
                dv = clampw(s - fx_mul(fk, x2, f), f);
            end
            MODEL_WS:
            begin
                d = clampw(x2 - x1, f);
                den = fx_mul(d, d, f) + one;
                q = clampw((d * (longint'(1) << FRAC)) / den, f);
                du = clampw(q - fx_mul(p2, x1, f), f);
                dv = fx_mul(p1, clampw(p3 - d, f), f);
            end
            default: ;
        endcase
        r.nf = 24'(clampw(x1 + fx_mul(dt, du, f), f));
        r.ns = 24'(clampw(x2 + fx_mul(dt, dv, f), f));
        r.sat = f;
        return r;
    endfunction

    // write enable stays high across a run of writes; the caller drops it
    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_MODEL: sh_model = val[1:0];
            CFG_STEP:  sh_dt    = val[22:0];
            CFG_P1:    sh_p1    = val;
            CFG_P2:    sh_p2    = val;
            CFG_P3:    sh_p3    = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [1:0] m, logic [22:0] dt, logic [23:0] a,
                             logic [23:0] b, logic [23:0] c);
        write_reg(CFG_MODEL, {22'd0, m});
        write_reg(CFG_STEP, {1'b0, dt});
        write_reg(CFG_P1, a);
        write_reg(CFG_P2, b);
        write_reg(CFG_P3, c);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high across back-to-back items
    task automatic send_cell(logic [23:0] a, logic [23:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            cell_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_in.valid        <= 1'b1;
        cell_in.field_first  <= a;
        cell_in.field_second <= b;
        do
            @(posedge clk);
        while (!cell_in.ready);
        sb.note_cell(react_step(a, b));
        accepted++;
    endtask

    task automatic stop_sending();
        cell_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 262143)) - 24'd131072;
            3: return 24'($urandom_range(0, 65535)) - 24'd32768;
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int n;
        cell_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                cell_out.ready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_long = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                cell_out.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                cell_out.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cell_out.valid && cell_out.ready)
        begin
            if (cell_out.saturated)
                sat_seen++;
            sb.check_cell(cell_out.next_first, cell_out.next_second, cell_out.saturated);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("reaction_kinetics_cell_update verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] edge_vals[6];
        sb = new();
        cycles = 0;
        quiet = 0;
        hold_long = 0;
        accepted = 0;
        sat_seen = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cell_in.valid = 1'b0;
        cell_in.field_first = '0;
        cell_in.field_second = '0;
        sh_model = MODEL_GL;
        sh_dt = 23'd6554;
        sh_p1 = 24'sd65536;
        sh_p2 = 24'sd0;
        sh_p3 = 24'sd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h010000, 24'hFF0000, 24'h000001};
        // directed: reset defaults, then each model incl. unused selector
        for (int m = 0; m < 4; m++)
        begin
            if (m > 0)
                configure(2'(m), 23'd6554, 24'h004000, 24'h00F000, 24'h00C000);
            for (int i = 0; i < 6; i += 2)
                send_cell(edge_vals[i], edge_vals[i + 1]);
            send_cell(24'h008000, 24'h004000);
            stop_sending();
            drain();
        end

        // random phases over several settings, extremes included
        for (int ph = 0; ph < 10; ph++)
        begin
            logic [22:0] dt;
            case (ph)
                0: dt = 23'h7FFFFF;
                1: dt = 23'd0;
                default: dt = (ph % 2) ? 23'($urandom_range(0, 65536)) : 23'($urandom);
            endcase
            configure(2'(ph % 4 == 3 ? $urandom_range(0, 3) : ph % 3), dt,
                      ph == 0 ? 24'h7FFFFF : (ph == 1 ? 24'h800000 : rand_word()),
                      ph == 0 ? 24'h800000 : rand_word(),
                      ph == 1 ? 24'h7FFFFF : rand_word());
            if (ph == 4)
                hold_long = 1;
            if (ph == 9)
                quiet = 1;
            repeat (65)
                send_cell(rand_word(), rand_word());
            stop_sending();
            drain();
        end

        $display("%0d cells sent over 4 models and 14 settings, %0d results checked",
                 accepted, sb.checked);
        $display("%0d results carried the clamp flag, %0d mismatches", sat_seen,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("reaction_kinetics_cell_update verification clean");
        else
            $display("reaction_kinetics_cell_update verification failed");
        $finish;
    end
endmodule
